### hdl/stwe_pkg.sv
// Package for the session table: sizes, op and status codes, memory word layout.
// No dependencies.
`default_nettype none
package stwe_pkg;
  localparam int unsigned Entries  = 1024;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned KeyBits  = 64;
  localparam int unsigned UserBits = 64;
  localparam int unsigned ExpW     = 32;
  localparam int unsigned WordW    = 1 + KeyBits + UserBits + ExpW;
  localparam int unsigned SlotW    = 10;

  typedef enum logic [1:0] {
    OpTick = 2'd0, OpCreate = 2'd1, OpLookup = 2'd2, OpDestroy = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StFull = 2'd1, StNotFound = 2'd2, StTick = 2'd3
  } status_e;

  typedef struct packed {
    logic                vld;
    logic [KeyBits-1:0]  key;
    logic [UserBits-1:0] user;
    logic [ExpW-1:0]     exp;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] session_key;
    logic [63:0] user_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] user_found;
    logic [9:0]  slot_index;
  } rsp_t;
endpackage
`default_nettype wire

### hdl/stwe_if.sv
// Valid/ready channel interface carrying one packed payload.
// Depends on stwe_pkg for the payload types.
`default_nettype none
interface stwe_req_if;
  import stwe_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stwe_rsp_if;
  import stwe_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/stwe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module stwe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/session_table_with_expiry_core.sv
// Session table with idle expiry built on one entry memory; uses stwe_pkg, stwe_if, stwe_ram.
// A tick is answered straight from the idle state; create/lookup/destroy scan every entry,
// reading one per cycle through the entry memory, then write back and load the result.
// One item at a time: ready stays low from acceptance until the result has been taken.
// Reset: async active low; ttl 3600, clock zero, then the clear state invalidates every entry.
`default_nettype none
module session_table_with_expiry_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stwe_req_if.sink         req,
  stwe_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import stwe_pkg::*;

  typedef enum logic [4:0] {
    SClear = 5'b00001,
    SIdle  = 5'b00010,
    SScan  = 5'b00100,
    SFin   = 5'b01000,
    SOut   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [15:0]      ttl_q;
  logic [ExpW-1:0]  now_q, now_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;        // read address counter
  logic [IdxW-1:0]  chk_q, chk_d;        // index of word now on rdata
  req_t             cur_q, cur_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hidx_q, hidx_d;
  entry_t           hent_q, hent_d;
  rsp_t             out_q, out_d;
  logic             ovld_q, ovld_d;

  logic             we;
  logic [IdxW-1:0]  waddr;
  entry_t           wdata, rdata;
  logic [ExpW:0]    exp_sum;
  logic [ExpW-1:0]  new_exp;
  logic             live, expired, cfg_wr;

  stwe_ram #(.Width(WordW), .Depth(Entries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, ttl_q} : 32'd0;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  assign exp_sum = {1'b0, now_q} + {{(ExpW-15){1'b0}}, ttl_q};
  assign new_exp = exp_sum[ExpW] ? {ExpW{1'b1}} : exp_sum[ExpW-1:0];

  assign req.ready = (state_q == SIdle) && !ovld_q;
  assign rsp.valid = ovld_q;
  assign rsp.data  = out_q;

  // Sweep applies to create and lookup only.
  assign expired = (cur_q.op != OpDestroy) && (rdata.exp <= now_q);
  assign live    = rdata.vld && !expired;

  always_comb begin
    state_d = state_q;
    now_d   = now_q;
    ptr_d   = ptr_q;
    chk_d   = chk_q;
    cur_d   = cur_q;
    hit_d   = hit_q;
    hidx_d  = hidx_q;
    hent_d  = hent_q;
    out_d   = out_q;
    ovld_d  = ovld_q;
    we      = 1'b0;
    waddr   = chk_q;
    wdata   = rdata;
    if (rsp.valid && rsp.ready) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      SClear: begin
        // Invalidate every entry after reset.
        we          = 1'b1;
        waddr       = ptr_q;
        wdata       = '0;
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == IdxW'(Entries - 1)) begin
          ptr_d   = '0;
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (req.valid && req.ready) begin
          if (req.data.op == OpTick) begin
            if (now_q != {ExpW{1'b1}}) now_d = now_q + 1'b1;
            out_d  = '{status: StTick, user_found: '0, slot_index: '0};
            ovld_d = 1'b1;
          end else begin
            cur_d   = req.data;
            hit_d   = 1'b0;
            ptr_d   = IdxW'(1);
            chk_d   = '0;
            state_d = SScan;
          end
        end
      end
      SScan: begin
        // rdata holds entry chk_q; drop expired ones, track first match/free.
        if (rdata.vld && expired) begin
          we        = 1'b1;
          wdata.vld = 1'b0;
        end
        if (!hit_q) begin
          if ((cur_q.op == OpCreate) ? !live
              : (live && rdata.key == cur_q.session_key[KeyBits-1:0])) begin
            hit_d  = 1'b1;
            hidx_d = chk_q;
            hent_d = rdata;
          end
        end
        chk_d = chk_q + 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (chk_q == IdxW'(Entries - 1)) begin
          state_d = SFin;
        end
      end
      SFin: begin
        waddr = hidx_q;
        wdata = hent_q;
        out_d = '{status: StNotFound, user_found: '0, slot_index: '0};
        if (hit_q) begin
          we               = 1'b1;
          out_d.status     = StOk;
          out_d.slot_index = SlotW'(hidx_q);
          case (cur_q.op)
            OpCreate: begin
              wdata = '{vld: 1'b1, key: cur_q.session_key[KeyBits-1:0],
                        user: cur_q.user_tag[UserBits-1:0], exp: new_exp};
            end
            OpLookup: begin
              wdata.exp        = new_exp;
              out_d.user_found = 64'(hent_q.user);
            end
            default: wdata.vld = 1'b0;
          endcase
        end else if (cur_q.op == OpCreate) begin
          out_d.status = StFull;
        end
        ovld_d  = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        // Hold until the result is taken.
        if (!ovld_q) state_d = SIdle;
        ptr_d = '0;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ttl_q   <= 16'd3600;
      now_q   <= '0;
      ptr_q   <= '0;
      chk_q   <= '0;
      hit_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) ttl_q <= pwdata[15:0];
      now_q   <= now_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
      hit_q   <= hit_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hidx_q <= hidx_d;
    hent_q <= hent_d;
    out_q  <= out_d;
  end
endmodule
`default_nettype wire

### hdl/stwe_checker.sv
// Port-level assertions for the session table core, bound to the top level.
// Depends on stwe_pkg.
`default_nettype none
module stwe_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_op_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_status_i,
  input wire logic [63:0] out_user_i,
  input wire logic [9:0]  out_slot_i
);
  import stwe_pkg::*;

  a_tick_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OpTick |=> out_valid_i && out_status_i == StTick)
    else $error("tick result missing");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("item taken while result pending");

  a_user_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != StOk |-> out_user_i == '0 && out_slot_i == '0)
    else $error("nonzero payload on failed result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result dropped under stall");
endmodule

bind session_table_with_expiry_core stwe_assert u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req.valid),
  .in_ready_i   (req.ready),
  .in_op_i      (req.data.op),
  .out_valid_i  (rsp.valid),
  .out_ready_i  (rsp.ready),
  .out_status_i (rsp.data.status),
  .out_user_i   (rsp.data.user_found),
  .out_slot_i   (rsp.data.slot_index)
);
`default_nettype wire

### tb/stwe_checker.sv
// Checker for the session table core: watches request and response channels,
// keeps its own table model and compares every response. Depends on stwe_pkg.
module stwe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  stwe_pkg::req_t req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  stwe_pkg::rsp_t rsp_data_i,
  input  logic [15:0] ttl_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          rsp_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stwe_pkg::*;

  localparam logic [31:0] NowMax = 32'hFFFF_FFFF;

  logic        live_q [Entries];
  logic [63:0] key_q  [Entries];
  logic [63:0] user_q [Entries];
  logic [31:0] exp_q  [Entries];
  logic [31:0] now_q;
  rsp_t        want_rsp_q [$];

  function automatic logic [31:0] expiry_at();
    logic [32:0] t;
    t = {1'b0, now_q} + {17'b0, ttl_i};
    return t[32] ? NowMax : t[31:0];
  endfunction

  // Update the table model for one request and return the response it implies.
  function automatic rsp_t table_step(req_t r);
    rsp_t o;
    int   hit;
    o = '0;
    o.status = StNotFound;
    hit = -1;
    if (r.op != OpTick && r.op != OpDestroy)
      for (int i = 0; i < Entries; i++)
        if (live_q[i] && exp_q[i] <= now_q) live_q[i] = 1'b0;
    case (op_e'(r.op))
      OpTick: begin
        if (now_q != NowMax) now_q++;
        o.status = StTick;
      end
      OpCreate: begin
        for (int i = 0; i < Entries; i++)
          if (!live_q[i]) begin hit = i; break; end
        if (hit < 0) o.status = StFull;
        else begin
          live_q[hit] = 1'b1;
          key_q[hit]  = r.session_key;
          user_q[hit] = r.user_tag;
          exp_q[hit]  = expiry_at();
          o.status = StOk;
          o.slot_index = hit[9:0];
        end
      end
      default: begin
        for (int i = 0; i < Entries; i++)
          if (live_q[i] && key_q[i] == r.session_key) begin hit = i; break; end
        if (hit >= 0) begin
          o.status = StOk;
          o.slot_index = hit[9:0];
          if (r.op == OpLookup) begin
            exp_q[hit] = expiry_at();
            o.user_found = user_q[hit];
          end else live_q[hit] = 1'b0;
        end
      end
    endcase
    return o;
  endfunction

  assign pending_o = want_rsp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t w;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) live_q[i] = 1'b0;
      now_q = '0;
      want_rsp_q.delete();
      fail_count_o <= 0;
      rsp_count_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        rsp_count_o <= rsp_count_o + 1;
        if (want_rsp_q.size() == 0) begin
          $error("unexpected response status=%0d", rsp_data_i.status);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = want_rsp_q.pop_front();
          if (w != rsp_data_i) fail_count_o <= fail_count_o + 1;
          if (w.status != rsp_data_i.status)
            $error("status: expected %0d got %0d", w.status, rsp_data_i.status);
          if (w.user_found != rsp_data_i.user_found)
            $error("user_found: expected %h got %h", w.user_found, rsp_data_i.user_found);
          if (w.slot_index != rsp_data_i.slot_index)
            $error("slot_index: expected %0d got %0d", w.slot_index, rsp_data_i.slot_index);
        end
      end
      if (req_valid_i && req_ready_i) want_rsp_q.push_back(table_step(req_data_i));
    end
  end
endmodule

### tb/tb_session_table_with_expiry_core.sv
// Top of the session table testbench: clock, reset, APB setup, request stimulus
// and verdict. Depends on stwe_pkg, stwe_if.sv, stwe_checker.sv and the core.
module tb_session_table_with_expiry_core;
  timeunit 1ns;
  timeprecision 1ps;
  import stwe_pkg::*;

  localparam int CycleLimit = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [15:0] ttl_q = 16'd3600;   // mirror of the lifetime register
  int          fail_count, pending, rsp_count;
  int          cycle_count = 0;
  int          sent = 0;
  logic [63:0] key_pool [8];       // small key set so lookups and destroys hit

  stwe_req_if req ();
  stwe_rsp_if rsp ();

  session_table_with_expiry_core u_top (
    .clk_i, .rst_ni, .req, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stwe_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_i(req.ready), .req_data_i(req.data),
    .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_data_i(rsp.data),
    .ttl_i(ttl_q), .fail_count_o(fail_count), .pending_o(pending),
    .rsp_count_o(rsp_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
  end

  // Receiver: stall at random, with calm stretches where ready holds high.
  always @(posedge clk_i) begin
    if ((cycle_count / 4000) % 3 == 2) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Write one register through a setup and an access phase; the mirror
  // follows at the same edge the core takes the write.
  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 2'd0) ttl_q <= data[15:0];
  endtask

  // Offer one item and hold it until the core takes it.
  task automatic send_item(input op_e op, input logic [63:0] k, input logic [63:0] u);
    req.valid <= 1'b1;
    req.data  <= '{op: op, session_key: k, user_tag: u};
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic idle_sender(input int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for every expected response, then let the core settle.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    int   burst;
    op_e  op;
    logic [63:0] k;
    for (int n = 0; n < count;) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && n < count; b++, n++) begin
        op = op_e'($urandom_range(0, 3));
        // Mostly known keys; sometimes a fresh random one.
        k = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, 7)];
        send_item(op, k, {$urandom, $urandom});
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 20));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every op, duplicates, stale destroy, zero lifetime.
    send_item(OpLookup, '0, '0);
    send_item(OpDestroy, '1, '0);
    send_item(OpCreate, '0, '1);
    send_item(OpCreate, '1, '0);
    send_item(OpCreate, '1, 64'hA5A5_5A5A_F0F0_0F0F);
    send_item(OpLookup, '1, '0);
    send_item(OpLookup, '0, '0);
    send_item(OpDestroy, '1, '0);
    send_item(OpLookup, '1, '0);
    send_item(OpTick, '1, '1);
    drain();
    apb_write(2'd0, 32'd0);            // zero lifetime
    send_item(OpCreate, 64'h1234, 64'h55);
    send_item(OpDestroy, 64'h1234, '0); // stale, still removed
    send_item(OpCreate, 64'h77, 64'h66);
    send_item(OpLookup, 64'h77, '0);    // swept first, so not found
    drain();
    apb_write(2'd0, 32'd1);
    send_item(OpCreate, 64'h88, 64'h99);
    send_item(OpTick, '0, '0);
    send_item(OpLookup, 64'h88, '0);
    drain();
    apb_write(2'd3, 32'hFFFF);         // beyond the list, ignored by the core
    ttl_q <= 16'd1;

    apb_write(2'd0, 32'd3);
    random_phase(200);
    drain();
    apb_write(2'd0, 32'd65535);
    random_phase(200);
    drain();
    apb_write(2'd0, 32'd2);
    random_phase(180);
    drain();

    $display("Ran %0d items, %0d responses, lifetimes 0, 1, 2, 3 and 65535.",
             sent, rsp_count);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
